FILE: src/lfmp_pkg.sv
// Shared types and constants for the length-framed message parser.
`default_nettype none
package lfmp_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned LenW  = 32;

    typedef enum logic [3:0] {
        PH_HEAD    = 4'd0,
        PH_SYNC    = 4'd1,
        PH_PLAT    = 4'd2,
        PH_RSVD    = 4'd3,
        PH_LEN0    = 4'd4,
        PH_LEN1    = 4'd5,
        PH_LEN2    = 4'd6,
        PH_LEN3    = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_CHECK   = 4'd9,
        PH_END     = 4'd10
    } phase_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                 result_kind;
        logic [ByteW-1:0]      payload_byte;
        logic [ByteW-1:0]      frame_sync;
        logic [ByteW-1:0]      frame_platform;
        logic [LenW-1:0]       frame_length;
        logic                  checksum_ok;
        logic                  frame_last;
    } result_t;

endpackage
`default_nettype wire

FILE: src/length_framed_message_parser.sv
// Usage notes:
// Slave stream (s_*) takes one received frame byte per transfer in s_tdata.
// A frame is head, sync, platform, reserved, four length bytes (LSB first),
// payload, checksum and end byte. Master stream (m_*) carries results:
// m_tuser = 0 passes one payload byte, m_tuser = 1 is the frame summary
// (sync, platform, length, checksum match) and is flagged with m_tlast.
// Header, length and end bytes produce no transfer on the master side.
// Each result shows on m_* in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the receiver stalls; the phase
// machine and 8-bit sum step per byte; the output register holds results.
// s_tready stays high while the output register is empty or being drained,
// so a new byte is taken in the same cycle that the previous result leaves.
// When the receiver stalls, hold the pending result and stop taking input.
// Reset (aresetn low, synchronous) drops any pending result and returns
// the parser to waiting for a head byte with the running sum cleared.
`default_nettype none
module length_framed_message_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] payload_byte, [15:8] frame_sync, [23:16] frame_platform,
    // [55:24] frame_length, [56] checksum_ok, [63:57] zero
    output logic [63:0]      m_tdata,
    output logic [0:0]       m_tuser,   // [0] result_kind
    output logic             m_tlast    // frame_last
);

    logic               in_fire;
    logic               res_valid;
    lfmp_pkg::result_t  res;

    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg;
    logic        m_user_reg;
    logic        m_last_reg;

    // Accept while the output slot is free or emptying this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    lfmp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_fire) begin
            m_valid_next = res_valid;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load payload only on a transfer that yields a result
    always_ff @(posedge aclk) begin
        if (in_fire && res_valid) begin
            m_data_reg <= {7'd0, res.checksum_ok, res.frame_length,
                           res.frame_platform, res.frame_sync, res.payload_byte};
            m_user_reg <= res.result_kind;
            m_last_reg <= res.frame_last;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;
    assign m_tlast    = m_last_reg;

endmodule
`default_nettype wire

FILE: src/lfmp_core.sv
// Frame phase machine, running checksum and header capture.
`default_nettype none
module lfmp_core (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_fire,
    input  wire logic [7:0]             in_byte,
    output logic                        res_valid,
    output lfmp_pkg::result_t           res
);

    lfmp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  sync_reg, sync_next;
    logic [7:0]  plat_reg, plat_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] left_dec;
    logic [31:0] len_merged;

    assign left_dec = left_reg - 32'd1;

    always_comb begin
        len_merged = len_reg;
        case (phase_reg)
            lfmp_pkg::PH_LEN0: len_merged[7:0]   = in_byte;
            lfmp_pkg::PH_LEN1: len_merged[15:8]  = in_byte;
            lfmp_pkg::PH_LEN2: len_merged[23:16] = in_byte;
            lfmp_pkg::PH_LEN3: len_merged[31:24] = in_byte;
            default:           len_merged = len_reg;
        endcase
    end

    // Next phase
    always_comb begin
        case (phase_reg)
            lfmp_pkg::PH_SYNC:    phase_next = lfmp_pkg::PH_PLAT;
            lfmp_pkg::PH_PLAT:    phase_next = lfmp_pkg::PH_RSVD;
            lfmp_pkg::PH_RSVD:    phase_next = lfmp_pkg::PH_LEN0;
            lfmp_pkg::PH_LEN0:    phase_next = lfmp_pkg::PH_LEN1;
            lfmp_pkg::PH_LEN1:    phase_next = lfmp_pkg::PH_LEN2;
            lfmp_pkg::PH_LEN2:    phase_next = lfmp_pkg::PH_LEN3;
            lfmp_pkg::PH_LEN3:    phase_next = (len_merged == '0) ? lfmp_pkg::PH_CHECK
                                                                  : lfmp_pkg::PH_PAYLOAD;
            lfmp_pkg::PH_PAYLOAD: phase_next = (left_dec == '0) ? lfmp_pkg::PH_CHECK
                                                                : lfmp_pkg::PH_PAYLOAD;
            lfmp_pkg::PH_CHECK:   phase_next = lfmp_pkg::PH_END;
            lfmp_pkg::PH_END:     phase_next = lfmp_pkg::PH_HEAD;
            default:              phase_next = lfmp_pkg::PH_SYNC;
        endcase
    end

    // Datapath updates and result
    always_comb begin
        sum_next  = sum_reg;
        sync_next = sync_reg;
        plat_next = plat_reg;
        len_next  = len_reg;
        left_next = left_reg;
        res_valid = 1'b0;
        res       = '0;
        case (phase_reg)
            lfmp_pkg::PH_SYNC: begin
                sum_next  = sum_reg + in_byte;
                sync_next = in_byte;
            end
            lfmp_pkg::PH_PLAT: begin
                sum_next  = sum_reg + in_byte;
                plat_next = in_byte;
            end
            lfmp_pkg::PH_RSVD: begin
                sum_next = sum_reg + in_byte;
                len_next = '0;
            end
            lfmp_pkg::PH_LEN0, lfmp_pkg::PH_LEN1, lfmp_pkg::PH_LEN2: begin
                sum_next = sum_reg + in_byte;
                len_next = len_merged;
            end
            lfmp_pkg::PH_LEN3: begin
                sum_next  = sum_reg + in_byte;
                len_next  = len_merged;
                left_next = len_merged;
            end
            lfmp_pkg::PH_PAYLOAD: begin
                sum_next         = sum_reg + in_byte;
                left_next        = left_dec;
                res_valid        = 1'b1;
                res.result_kind  = lfmp_pkg::KIND_PAYLOAD;
                res.payload_byte = in_byte;
            end
            lfmp_pkg::PH_CHECK: begin
                res_valid          = 1'b1;
                res.result_kind    = lfmp_pkg::KIND_SUMMARY;
                res.frame_sync     = sync_reg;
                res.frame_platform = plat_reg;
                res.frame_length   = len_reg;
                // byte matches the negated sum exactly when the two add to zero
                res.checksum_ok    = ((sum_reg + in_byte) == 8'd0);
                res.frame_last     = 1'b1;
            end
            lfmp_pkg::PH_END: begin
                sum_next = sum_reg;
            end
            default: begin
                sum_next  = in_byte;
                sync_next = '0;
                plat_next = '0;
                len_next  = '0;
                left_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lfmp_pkg::PH_HEAD;
            sum_reg   <= '0;
            sync_reg  <= '0;
            plat_reg  <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            sync_reg  <= sync_next;
            plat_reg  <= plat_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
        end
    end

endmodule
`default_nettype wire

FILE: sim/length_framed_message_parser_tb.sv
// Testbench for the length-framed message parser: random frames, scoreboard checks.
`timescale 1ns / 100ps

// Tracks the parser's frame state and holds the results it should produce.
class frame_scoreboard;
    lfmp_pkg::phase_t    ph;
    logic [7:0]          sum;
    logic [7:0]          sync_b;
    logic [7:0]          plat_b;
    logic [31:0]         len;
    logic [31:0]         left;
    lfmp_pkg::result_t   due_results[$];
    int                  failures;

    function new();
        ph       = lfmp_pkg::PH_HEAD;
        sum      = '0;
        sync_b   = '0;
        plat_b   = '0;
        len      = '0;
        left     = '0;
        failures = 0;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    // Advance the frame state by one accepted byte; queue any result it causes.
    function void note_byte(logic [7:0] b);
        lfmp_pkg::result_t r;
        r = '0;
        case (ph)
            lfmp_pkg::PH_SYNC: begin
                sum    = sum + b;
                sync_b = b;
                ph     = lfmp_pkg::PH_PLAT;
            end
            lfmp_pkg::PH_PLAT: begin
                sum    = sum + b;
                plat_b = b;
                ph     = lfmp_pkg::PH_RSVD;
            end
            lfmp_pkg::PH_RSVD: begin
                sum = sum + b;
                len = '0;
                ph  = lfmp_pkg::PH_LEN0;
            end
            lfmp_pkg::PH_LEN0, lfmp_pkg::PH_LEN1, lfmp_pkg::PH_LEN2, lfmp_pkg::PH_LEN3: begin
                sum = sum + b;
                len = len | (32'(b) << (8 * (ph - lfmp_pkg::PH_LEN0)));
                if (ph == lfmp_pkg::PH_LEN3) begin
                    left = len;
                    ph   = (len == 0) ? lfmp_pkg::PH_CHECK : lfmp_pkg::PH_PAYLOAD;
                end else begin
                    ph = lfmp_pkg::phase_t'(ph + 1);
                end
            end
            lfmp_pkg::PH_PAYLOAD: begin
                sum  = sum + b;
                left = left - 1;
                if (left == 0)
                    ph = lfmp_pkg::PH_CHECK;
                r.result_kind  = lfmp_pkg::KIND_PAYLOAD;
                r.payload_byte = b;
                due_results.push_back(r);
            end
            lfmp_pkg::PH_CHECK: begin
                r.result_kind    = lfmp_pkg::KIND_SUMMARY;
                r.frame_sync     = sync_b;
                r.frame_platform = plat_b;
                r.frame_length   = len;
                r.checksum_ok    = (b == 8'(-sum));
                r.frame_last     = 1'b1;
                due_results.push_back(r);
                ph = lfmp_pkg::PH_END;
            end
            lfmp_pkg::PH_END: ph = lfmp_pkg::PH_HEAD;
            default: begin
                sum    = b;
                sync_b = '0;
                plat_b = '0;
                len    = '0;
                left   = '0;
                ph     = lfmp_pkg::PH_SYNC;
            end
        endcase
    endfunction

    function void fail_field(string name, logic [31:0] want, logic [31:0] got);
        failures++;
        if (failures <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
    endfunction

    // Compare one accepted result transfer with the oldest queued result.
    function void check_result(logic [63:0] data, logic [0:0] user, logic last);
        lfmp_pkg::result_t want;
        if (due_results.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("%0t: unexpected result tdata=%0h tuser=%0b", $realtime, data, user);
            return;
        end
        want = due_results.pop_front();
        if (user[0] !== want.result_kind)
            fail_field("result_kind", 32'(want.result_kind), 32'(user[0]));
        if (data[7:0] !== want.payload_byte)
            fail_field("payload_byte", 32'(want.payload_byte), 32'(data[7:0]));
        if (data[15:8] !== want.frame_sync)
            fail_field("frame_sync", 32'(want.frame_sync), 32'(data[15:8]));
        if (data[23:16] !== want.frame_platform)
            fail_field("frame_platform", 32'(want.frame_platform), 32'(data[23:16]));
        if (data[55:24] !== want.frame_length)
            fail_field("frame_length", want.frame_length, data[55:24]);
        if (data[56] !== want.checksum_ok)
            fail_field("checksum_ok", 32'(want.checksum_ok), 32'(data[56]));
        if (last !== want.frame_last)
            fail_field("frame_last", 32'(want.frame_last), 32'(last));
    endfunction
endclass

module length_framed_message_parser_tb;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // [7:0] payload, [15:8] sync, [23:16] platform,
                             // [55:24] length, [56] checksum_ok
    logic [0:0]  m_tuser;    // [0] result_kind
    logic        m_tlast;    // frame_last

    frame_scoreboard sb;

    // Sender and receiver idling control.
    bit calm;        // no idling at all in the last part of the run
    bit press_on;    // sender keeps offering without gaps during the long hold-off
    bit hold_req;    // ask the receiver for one long hold-off
    int bytes_sent;

    length_framed_message_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the parser hangs or drops a result.
    initial begin
        #2_000_000;
        $display("** length_framed_message_parser: FAILED **");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off counted here in cycles.
    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = 60;
            end else if (stall == 0 && !calm && aresetn && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 9);
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Monitor: check every result transfer against the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Offer one byte, possibly after an idle burst, and hold it until it is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!calm && !press_on && $urandom_range(0, 5) == 0) begin
            gap      = $urandom_range(1, 9);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Build and send one frame. Extreme fill alternates 00/FF payload bytes;
    // corrupt flips the checksum so the parser must flag a mismatch.
    task automatic send_frame(input logic [7:0] head, input logic [7:0] sync_b,
                              input logic [7:0] plat_b, input logic [7:0] rsvd,
                              input int unsigned len, input bit corrupt,
                              input logic [7:0] tail, input bit extreme);
        logic [7:0]  acc;
        logic [7:0]  pb;
        logic [7:0]  ck;
        logic [31:0] len_v;
        len_v = len;
        acc   = head + sync_b + plat_b + rsvd;
        send_byte(head);
        send_byte(sync_b);
        send_byte(plat_b);
        send_byte(rsvd);
        for (int i = 0; i < 4; i++) begin
            acc = acc + len_v[8*i +: 8];
            send_byte(len_v[8*i +: 8]);
        end
        for (int i = 0; i < len; i++) begin
            pb  = extreme ? ((i % 2 == 0) ? 8'h00 : 8'hFF) : 8'($urandom);
            acc = acc + pb;
            send_byte(pb);
        end
        ck = 8'(-acc);
        if (corrupt)
            ck = ck ^ 8'($urandom_range(1, 255));
        send_byte(ck);
        send_byte(tail);
    endtask

    initial begin
        int unsigned len;
        int          pick;
        logic [7:0]  sync_b;
        sb         = new();
        calm       = 1'b0;
        press_on   = 1'b0;
        hold_req   = 1'b0;
        bytes_sent = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: empty payload with a good checksum and all-ones platform,
        // reserved and end bytes, then a short 00/FF payload with a broken checksum.
        send_frame(8'h00, 8'h01, 8'hFF, 8'hFF, 0, 1'b0, 8'hFF, 1'b0);
        send_frame(8'hFF, 8'h02, 8'h00, 8'h00, 3, 1'b1, 8'h00, 1'b1);

        // Long hold-off on the result side while the sender keeps offering,
        // so the output register fills and the input stalls.
        press_on = 1'b1;
        hold_req = 1'b1;
        send_frame(8'hAA, 8'h01, 8'h5A, 8'h00, 40, 1'b0, 8'h55, 1'b0);
        press_on = 1'b0;

        // Random frames: mostly short, well formed; some with bad checksums or
        // an arbitrary sync byte; head/platform/reserved/end bytes are random.
        while (bytes_sent < 500) begin
            if (bytes_sent >= 440)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(0, 8);
            else if (pick < 95)
                len = $urandom_range(9, 24);
            else
                len = $urandom_range(25, 60);
            sync_b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
            send_frame(8'($urandom), sync_b, 8'($urandom), 8'($urandom), len,
                       $urandom_range(0, 4) == 0, 8'($urandom), 1'b0);
        end
        s_tvalid = 1'b0;

        // Drain: wait for every queued result, then keep watching for strays.
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (sb.failures == 0)
            $display("** length_framed_message_parser: PASSED **");
        else
            $display("** length_framed_message_parser: FAILED **");
        $finish;
    end

endmodule
